// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WIP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wip assertion failed");

// next-cycle implication
`define WIP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wip assertion failed");

`else

`define WIP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WIP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/wip_pkg.sv
// ----------------------------------------------------------------------------
// wip_pkg
// shared constants and codes of the wavetable interpolating player
// ----------------------------------------------------------------------------
package wip_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int RATE_W    = 29;
    localparam int LEN_W     = 13;
    localparam int ADDR_IN_W = 12;
    localparam int KIND_W    = 2;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4096);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD    = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_ADD     = 2'd2,
        KIND_RESTART = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_RATE   = 2'd0,
        REG_LENGTH = 2'd1,
        REG_LOOP   = 2'd2,
        REG_PHASE  = 2'd3
    } reg_idx_t;

endpackage

// File: rtl/wavetable_interp_player_top.sv
// ----------------------------------------------------------------------------
// wavetable_interp_player_top
// sample table playback with a fixed-point time accumulator and linear
// interpolation between neighboring table entries
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_        in         tuser: kind; tdata: load_addr, load_value, time_delta
// m_        out        tdata: sample_out, finished (ticks only)
// apb       in/out     play_rate, table_length, loop_mode, phase_shift
//
// one request per cycle unless the pipeline is full; a tick result passes every stage into m_tdata
// time accumulator updates at acceptance, table sits in a 2-read/1-write ram
// a stalled output fills empty stages first, s_tready drops when all are full
// synchronous active-low reset clears control and registers, not the table
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wavetable_interp_player_top
    import wip_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IN_BITS    = ADDR_IN_W + SAMPLE_BITS + RATE_W,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((SAMPLE_BITS + 1 + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // load_addr, load_value, time_delta
    input  logic [KIND_W-1:0] s_tuser,   // kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // sample_out, finished
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW  = $clog2(TABLE_DEPTH + 1);
    localparam int TW  = AW + FRAC_BITS;
    localparam int XW  = ((TW > RATE_W) ? TW : RATE_W) + 2;
    localparam int PW  = FRAC_BITS + SAMPLE_BITS + 2;
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [TW-1:0] t;
        logic          hit;
    } fold_t;

    function automatic logic [NW-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [31:0] w;
        begin
            w = 32'(v);
            if (w < 32'd2) begin
                w = 32'd2;
            end else if (w > 32'(TABLE_DEPTH)) begin
                w = 32'(TABLE_DEPTH);
            end
            return NW'(w);
        end
    endfunction

    // wrap (loop) or hold (one-shot) into [0, lf)
    function automatic fold_t fold(input logic signed [XW-1:0] t,
                                   input logic                 lp,
                                   input logic signed [XW-1:0] lf,
                                   input logic signed [XW-1:0] lastt);
        logic signed [XW-1:0] tm;
        logic signed [XW-1:0] tp;
        logic signed [XW-1:0] r;
        fold_t                o;
        begin
            o.hit = 1'b0;
            tm    = t - lf;
            tp    = t + lf;
            if (lp) begin
                if (t >= lf) begin
                    r = tm;
                end else if (t[XW-1]) begin
                    r = tp;
                end else begin
                    r = t;
                end
                if (r >= lf) begin
                    r = lf - XW'(1);
                end else if (r[XW-1]) begin
                    r = '0;
                end
            end else begin
                if (t >= lf) begin
                    r     = lastt;
                    o.hit = 1'b1;
                end else if (t[XW-1]) begin
                    r = '0;
                end else begin
                    r = t;
                end
            end
            o.t = r[TW-1:0];
            return o;
        end
    endfunction

    // configuration
    logic signed [RATE_W-1:0] rate_reg;
    logic signed [RATE_W-1:0] phase_reg;
    logic [LEN_W-1:0]         len_raw_reg;
    logic [NW-1:0]            eff_len_reg;
    logic                     loop_reg;
    logic                     cfg_wr;
    reg_idx_t                 cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg    <= RATE_RESET;
            phase_reg   <= '0;
            len_raw_reg <= LEN_RESET;
            eff_len_reg <= clamp_len(LEN_RESET);
            loop_reg    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_RATE:   rate_reg <= pwdata[RATE_W-1:0];
                REG_LENGTH: begin
                    len_raw_reg <= pwdata[LEN_W-1:0];
                    eff_len_reg <= clamp_len(pwdata[LEN_W-1:0]);
                end
                REG_LOOP:   loop_reg <= pwdata[0];
                REG_PHASE:  phase_reg <= pwdata[RATE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_RATE:   prdata = APB_DW'($unsigned(rate_reg));
            REG_LENGTH: prdata = APB_DW'(len_raw_reg);
            REG_LOOP:   prdata = APB_DW'(loop_reg);
            REG_PHASE:  prdata = APB_DW'($unsigned(phase_reg));
        endcase
    end

    // derived length values
    logic [NW-1:0]        len_m1;
    logic [AW-1:0]        last_idx;
    logic signed [XW-1:0] lf_x;
    logic signed [XW-1:0] last_x;

    assign len_m1   = eff_len_reg - NW'(1);
    assign last_idx = AW'(len_m1);
    assign lf_x     = $signed(XW'({eff_len_reg, {FRAC_BITS{1'b0}}}));
    assign last_x   = $signed(XW'({len_m1, {FRAC_BITS{1'b0}}}));

    // input fields
    kind_t                         in_kind;
    logic [ADDR_IN_W-1:0]          in_addr;
    logic [SAMPLE_BITS-1:0]        in_value;
    logic signed [RATE_W-1:0]      in_delta;

    assign in_kind  = kind_t'(s_tuser);
    assign in_addr  = s_tdata[ADDR_IN_W-1:0];
    assign in_value = s_tdata[ADDR_IN_W +: SAMPLE_BITS];
    assign in_delta = $signed(s_tdata[ADDR_IN_W + SAMPLE_BITS +: RATE_W]);

    // pipeline enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, mv_reg;
    logic en1, en2, en3, en4, en_out, acc;

    assign en_out   = !mv_reg || m_tready;
    assign en4      = !v4_reg || en_out;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign acc      = s_tvalid && s_tready;

    // time accumulator
    logic [TW-1:0] play_time_reg;
    logic          done_reg;
    logic signed [XW-1:0] time_x;
    fold_t         fold_tick;
    fold_t         fold_add;

    assign time_x    = $signed(XW'(play_time_reg));
    assign fold_tick = fold(time_x + XW'(rate_reg), loop_reg, lf_x, last_x);
    assign fold_add  = fold(time_x + XW'(in_delta), loop_reg, lf_x, last_x);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            play_time_reg <= '0;
            done_reg      <= 1'b0;
        end else if (cfg_wr && cfg_idx == REG_LOOP) begin
            play_time_reg <= '0;
        end else if (acc) begin
            case (in_kind)
                KIND_TICK: begin
                    play_time_reg <= fold_tick.t;
                    done_reg      <= done_reg | fold_tick.hit;
                end
                KIND_ADD: begin
                    play_time_reg <= fold_add.t;
                    done_reg      <= done_reg | fold_add.hit;
                end
                KIND_RESTART: begin
                    play_time_reg <= '0;
                    done_reg      <= 1'b0;
                end
                KIND_LOAD: begin
                end
                default: begin
                end
            endcase
        end
    end

    // stage payloads
    logic [TW-1:0]                t1_reg;
    logic                         d1_reg;
    logic                         tick1_reg;
    logic [ADDR_IN_W-1:0]         la1_reg;
    logic [SAMPLE_BITS-1:0]       lv1_reg;
    logic [TW-1:0]                rt2_reg;
    logic                         d2_reg;
    logic [FRAC_BITS-1:0]         frac3_reg;
    logic                         d3_reg;
    logic [SAMPLE_BITS-1:0]       rd0_reg;
    logic [SAMPLE_BITS-1:0]       rd1_reg;
    logic signed [SAMPLE_BITS-1:0] s0_4_reg;
    logic signed [PW-1:0]         prod4_reg;
    logic                         d4_reg;
    logic [SAMPLE_BITS-1:0]       sample_reg;
    logic                         fin_reg;

    fold_t fold_ph;
    assign fold_ph = fold($signed(XW'(t1_reg)) + XW'(phase_reg), loop_reg, lf_x, last_x);

    // neighbor addresses
    logic [AW-1:0] rd_addr0;
    logic [AW-1:0] rd_addr1;
    logic [AW-1:0] rd_addr0_inc;

    assign rd_addr0     = rt2_reg[TW-1:FRAC_BITS];
    assign rd_addr0_inc = rd_addr0 + AW'(1);
    assign rd_addr1     = (rd_addr0 == last_idx) ? (loop_reg ? '0 : last_idx) : rd_addr0_inc;

    // interpolation arithmetic
    logic signed [SAMPLE_BITS-1:0] s0_3;
    logic signed [SAMPLE_BITS-1:0] s1_3;
    logic signed [SAMPLE_BITS:0]   diff3;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [PW-1:0]          prod3;
    logic signed [PW-1:0]          step4;
    logic signed [PW-1:0]          sum4;

    assign s0_3   = $signed(rd0_reg);
    assign s1_3   = $signed(rd1_reg);
    assign diff3  = (SAMPLE_BITS + 1)'(s1_3) - (SAMPLE_BITS + 1)'(s0_3);
    assign frac_s = $signed({1'b0, frac3_reg});
    assign prod3  = PW'(frac_s) * PW'(diff3);
    assign step4  = prod4_reg >>> FRAC_BITS;
    assign sum4   = PW'(s0_4_reg) + step4;

    // sample memory
    logic [SAMPLE_BITS-1:0] table_mem [TABLE_DEPTH];
    logic                   mem_we;

    assign mem_we = en2 && v1_reg && !tick1_reg && (32'(la1_reg) < TABLE_DEPTH);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[AW'(la1_reg)] <= lv1_reg;
        end
        if (en3 && v2_reg) begin
            rd0_reg <= table_mem[rd_addr0];
            rd1_reg <= table_mem[rd_addr1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= acc && (in_kind == KIND_TICK || in_kind == KIND_LOAD);
            end
            if (en2) begin
                v2_reg <= v1_reg && tick1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
            if (en_out) begin
                mv_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && acc) begin
            t1_reg    <= fold_tick.t;
            d1_reg    <= done_reg | fold_tick.hit;
            tick1_reg <= (in_kind == KIND_TICK);
            la1_reg   <= in_addr;
            lv1_reg   <= in_value;
        end
        if (en2 && v1_reg) begin
            rt2_reg <= fold_ph.t;
            d2_reg  <= d1_reg;
        end
        if (en3 && v2_reg) begin
            frac3_reg <= rt2_reg[FRAC_BITS-1:0];
            d3_reg    <= d2_reg;
        end
        if (en4 && v3_reg) begin
            s0_4_reg  <= s0_3;
            prod4_reg <= prod3;
            d4_reg    <= d3_reg;
        end
        if (en_out && v4_reg) begin
            sample_reg <= sum4[SAMPLE_BITS-1:0];
            fin_reg    <= d4_reg;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = OUT_W'({fin_reg, sample_reg});

    // checks
    `WIP_ASSERT_NXT(a_out_from_pipe, aclk, aresetn, v4_reg && en_out, m_tvalid)
    `WIP_ASSERT_IMP(a_done_oneshot, aclk, aresetn, $rose(done_reg), !$past(loop_reg))
    `WIP_ASSERT_IMP(a_nbr_addr, aclk, aresetn, v2_reg, (rd_addr1 == rd_addr0_inc) || (rd_addr0 == last_idx))

endmodule

// File: test/wavetable_interp_player_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wavetable_interp_player_checker
// follows register writes and accepted requests, keeps its own sample table,
// playback time and done flag, and compares every tick result in order
// ----------------------------------------------------------------------------
module wavetable_interp_player_checker
    import wip_pkg::*;
#(
    parameter int IN_W  = 64,
    parameter int OUT_W = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // load_addr, load_value, time_delta
    input  logic [KIND_W-1:0] s_tuser,   // kind
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,   // sample_out, finished
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                fail_count,
    output int                tones_due
);

    localparam int FB    = FRAC_BITS_DEF;
    localparam int SB    = SAMPLE_BITS_DEF;
    localparam int POS_W = FB + ADDR_IN_W;

    typedef struct packed {
        logic signed [SB-1:0] sample;
        logic                 finished;
    } tone_t;

    logic signed [RATE_W-1:0] rate_q;
    logic signed [RATE_W-1:0] phase_q;
    logic [LEN_W-1:0]         len_q;
    logic                     loop_q;
    logic signed [SB-1:0]     wave_mem [TABLE_DEPTH_DEF];
    logic [POS_W-1:0]         play_pos;
    logic                     done_q;
    tone_t                    tone_q [$];

    function automatic longint live_len();
        if (len_q < 2) return 2;
        if (len_q > TABLE_DEPTH_DEF) return TABLE_DEPTH_DEF;
        return longint'(len_q);
    endfunction

    // single wrap in loop mode, clamp at the ends in one-shot mode
    function automatic longint fold_time(longint t, output logic at_end);
        longint n;
        longint lf;
        n = live_len();
        lf = n <<< FB;
        at_end = 1'b0;
        if (loop_q) begin
            if (t >= lf) t -= lf;
            else if (t < 0) t += lf;
            if (t >= lf) t = lf - 1;
            else if (t < 0) t = 0;
        end else if (t >= lf) begin
            t = (n - 1) <<< FB;
            at_end = 1'b1;
        end else if (t < 0) begin
            t = 0;
        end
        return t;
    endfunction

    function automatic tone_t tick_tone();
        longint n;
        longint pos;
        longint rd;
        longint idx;
        longint frac;
        longint s0;
        longint s1;
        longint prod;
        logic   hit;
        logic   unused_hit;
        tone_t  tone;
        n = live_len();
        pos = fold_time(longint'(play_pos) + longint'(rate_q), hit);
        if (hit) done_q = 1'b1;
        play_pos = POS_W'(pos);
        rd = fold_time(pos + longint'(phase_q), unused_hit);
        idx = rd >>> FB;
        frac = rd & ((longint'(1) <<< FB) - 1);
        s0 = wave_mem[int'(idx)];
        if (idx + 1 < n) s1 = wave_mem[int'(idx + 1)];
        else if (loop_q) s1 = wave_mem[0];
        else s1 = wave_mem[int'(n - 1)];
        prod = frac * (s1 - s0);
        tone.sample = SB'(s0 + (prod >>> FB));
        tone.finished = done_q;
        return tone;
    endfunction

    always @(posedge aclk) begin
        tone_t                    want;
        logic signed [SB-1:0]     got;
        logic signed [RATE_W-1:0] delta;
        logic                     hit;
        if (!aresetn) begin
            rate_q = RATE_W'(1 << FB);
            len_q = LEN_RESET;
            loop_q = 1'b0;
            phase_q = '0;
            play_pos = '0;
            done_q = 1'b0;
            tone_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[SB-1:0];
                if (tone_q.size() == 0) begin
                    $error("result with no tick pending: sample_out %0d", got);
                    fail_count++;
                end else begin
                    want = tone_q.pop_front();
                    if (got !== want.sample) begin
                        $error("sample_out: expected %0d, got %0d", want.sample, got);
                        fail_count++;
                    end
                    if (m_tdata[SB] !== want.finished) begin
                        $error("finished: expected %0d, got %0d", want.finished, m_tdata[SB]);
                        fail_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_RATE:   rate_q = pwdata[RATE_W-1:0];
                    REG_LENGTH: len_q = pwdata[LEN_W-1:0];
                    REG_LOOP: begin
                        loop_q = pwdata[0];
                        play_pos = '0;
                    end
                    REG_PHASE:  phase_q = pwdata[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                case (kind_t'(s_tuser))
                    KIND_LOAD:
                        wave_mem[s_tdata[ADDR_IN_W-1:0]] = s_tdata[ADDR_IN_W +: SB];
                    KIND_TICK:
                        tone_q.push_back(tick_tone());
                    KIND_ADD: begin
                        delta = s_tdata[ADDR_IN_W + SB +: RATE_W];
                        play_pos = POS_W'(fold_time(longint'(play_pos) + longint'(delta), hit));
                        if (hit) done_q = 1'b1;
                    end
                    KIND_RESTART: begin
                        play_pos = '0;
                        done_q = 1'b0;
                    end
                    default: ;
                endcase
            end
        end
        tones_due = tone_q.size();
    end

endmodule

// File: test/tb_wavetable_interp_player_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wavetable_interp_player_top
// fills the low table entries, runs directed playback corner cases and then random
// register settings and request mixes with random idling on both channels
// ----------------------------------------------------------------------------
module tb_wavetable_interp_player_top;
    import wip_pkg::*;

    localparam int IN_W          = ((ADDR_IN_W + SAMPLE_BITS_DEF + RATE_W + 7) / 8) * 8;
    localparam int OUT_W         = ((SAMPLE_BITS_DEF + 1 + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int FILL_LEN      = 256;
    localparam int RAND_PHASES   = 15;
    localparam int PHASE_ITEMS   = 50;
    localparam int LONG_HOLD     = 150;
    localparam int ONE_Q         = 1 << FRAC_BITS_DEF;
    localparam int Q_MAX         = (1 << (RATE_W - 1)) - 1;
    localparam int Q_MIN         = -(1 << (RATE_W - 1));

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;   // load_addr, load_value, time_delta
    logic [KIND_W-1:0] s_tuser;   // kind
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;   // sample_out, finished
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bit send_quiet;
    bit take_quiet;
    bit hold_req;
    int mismatches;
    int tones_due;

    wavetable_interp_player_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    wavetable_interp_player_checker #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (mismatches),
        .tones_due  (tones_due)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(10_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int eff_len_of(int len);
        if (len < 2) return 2;
        if (len > TABLE_DEPTH_DEF) return TABLE_DEPTH_DEF;
        return len;
    endfunction

    // signed q12.16 value, mostly within +-span
    function automatic int rand_q(int span);
        logic signed [RATE_W-1:0] raw;
        int                       mag;
        raw = RATE_W'($urandom);
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            1: return int'(raw);
            2: return 0;
            default: begin
                mag = $urandom_range(0, span - 1);
                return ($urandom_range(0, 2) == 0) ? -mag : mag;
            end
        endcase
    endfunction

    task automatic send_req(kind_t kind, logic [ADDR_IN_W-1:0] addr,
                            logic [SAMPLE_BITS_DEF-1:0] value, logic [RATE_W-1:0] delta);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= IN_W'({delta, value, addr});
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // drain the pipeline before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tones_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // result side, with one long hold-off on request
    initial begin
        int gap;
        bit hold_taken;
        m_tready = 1'b0;
        hold_taken = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = take_quiet ? 0 : $urandom_range(0, 12);
            if (hold_req && !hold_taken) begin
                gap = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        int                         cur_len;
        int                         span;
        int                         pick;
        logic [ADDR_IN_W-1:0]       addr;
        logic [SAMPLE_BITS_DEF-1:0] value;
        logic [RATE_W-1:0]          delta;
        kind_t                      kind;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_LOAD;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_quiet = 1'b1;
        take_quiet = 1'b0;
        hold_req = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // low entries written first, every random-phase length stays within them
        for (int i = 0; i < FILL_LEN; i++) begin
            if (i % 64 == 0) value = 16'h8000;
            else if (i % 64 == 1) value = 16'h7fff;
            else value = SAMPLE_BITS_DEF'($urandom);
            send_req(KIND_LOAD, ADDR_IN_W'(i), value, RATE_W'($urandom));
        end
        send_quiet = 1'b0;

        // one-shot at reset settings: clamps, end of table, restart
        send_req(KIND_LOAD, '0, 16'h8000, RATE_W'($urandom));
        send_req(KIND_LOAD, '1, 16'h7fff, RATE_W'($urandom));
        send_req(KIND_LOAD, 12'd1, 16'h7fff, RATE_W'($urandom));
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));
        send_req(KIND_ADD, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'(Q_MIN));
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));
        send_req(KIND_ADD, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'(Q_MAX));
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));
        send_req(KIND_RESTART, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));

        // loop mode: neighbor past the end wraps to entry zero
        settle();
        write_reg(REG_LOOP, 1);
        send_req(KIND_ADD, ADDR_IN_W'($urandom), 16'($urandom),
                 RATE_W'(4094 * ONE_Q + ONE_Q / 2));
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));
        send_req(KIND_ADD, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'(Q_MIN));

        settle();
        write_reg(REG_RATE, Q_MIN);
        write_reg(REG_PHASE, Q_MAX);
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));

        // length below the minimum with oversized steps saturates
        settle();
        write_reg(REG_LENGTH, 0);
        write_reg(REG_RATE, Q_MAX);
        write_reg(REG_PHASE, Q_MIN);
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));
        send_req(KIND_ADD, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'(Q_MAX));
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));

        settle();
        write_reg(REG_LENGTH, 1);
        write_reg(REG_LOOP, 0);
        write_reg(REG_RATE, Q_MIN);
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));
        send_req(KIND_ADD, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'(Q_MAX));
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));

        // length above the table depth
        settle();
        write_reg(REG_LENGTH, (1 << LEN_W) - 1);
        write_reg(REG_RATE, ONE_Q);
        write_reg(REG_PHASE, 0);
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));
        send_req(KIND_RESTART, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));
        send_req(KIND_TICK, ADDR_IN_W'($urandom), 16'($urandom), RATE_W'($urandom));

        cur_len = (1 << LEN_W) - 1;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            if (ph == 0 || $urandom_range(0, 2) != 0) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    case ($urandom_range(0, 4))
                        0: cur_len = 0;
                        1: cur_len = 1;
                        2: cur_len = 2;
                        3: cur_len = FILL_LEN;
                        default: cur_len = FILL_LEN - 1;
                    endcase
                end else if (pick < 3) begin
                    cur_len = $urandom_range(0, FILL_LEN);
                end else begin
                    cur_len = $urandom_range(2, 40);
                end
                write_reg(REG_LENGTH, cur_len);
            end
            span = eff_len_of(cur_len) * ONE_Q;
            if (ph == 0 || $urandom_range(0, 1) != 0) write_reg(REG_RATE, rand_q(span));
            if (ph == 0 || $urandom_range(0, 1) != 0) write_reg(REG_LOOP, $urandom_range(0, 1));
            if (ph == 0 || $urandom_range(0, 1) != 0)
                write_reg(REG_PHASE, ($urandom_range(0, 2) == 0) ? 0 : rand_q(span));
            send_quiet = ($urandom_range(0, 3) == 0);
            take_quiet = ($urandom_range(0, 3) == 0);
            if (ph == 2) begin
                hold_req = 1'b1;
                send_quiet = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                kind = (pick < 55) ? KIND_TICK : (pick < 75) ? KIND_LOAD :
                       (pick < 90) ? KIND_ADD : KIND_RESTART;
                if ($urandom_range(0, 1) != 0)
                    addr = ADDR_IN_W'($urandom_range(0, eff_len_of(cur_len) - 1));
                else
                    addr = ADDR_IN_W'($urandom);
                if ($urandom_range(0, 9) == 0)
                    value = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                else
                    value = SAMPLE_BITS_DEF'($urandom);
                if (kind == KIND_ADD) delta = RATE_W'(rand_q(span));
                else delta = RATE_W'($urandom);
                send_req(kind, addr, value, delta);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/wip_pkg.sv
rtl/wavetable_interp_player_top.sv
test/wavetable_interp_player_checker.sv
test/tb_wavetable_interp_player_top.sv
